// ===== rtl/wldos_pkg.sv =====
// Shared types, codes and constants of the Wang-Landau histogram unit.
`timescale 1ns / 1ps
package wldos_pkg;

  localparam int MAX_BINS_DEF = 1024;
  localparam int HIT_W        = 32;
  localparam int DOS_W        = 48;
  localparam int FRAC_W       = 17;
  localparam int DIV_W        = 32;
  localparam int DIVR_W       = 31;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;

  localparam logic signed [31:0] EMIN_RST  = 32'sd0;
  localparam logic signed [31:0] EMAX_RST  = 32'sh7FFF_FFFF;
  localparam logic [30:0]        BINW_RST  = 31'd65536;
  localparam logic [10:0]        BINS_RST  = 11'd1024;
  localparam logic [31:0]        MODF_RST  = 32'd16777216;
  localparam logic [16:0]        FRAC_RST  = 17'd52429;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_CHECK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] RS_IN    = 2'd0;
  localparam logic [1:0] RS_BELOW = 2'd1;
  localparam logic [1:0] RS_ABOVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_EMIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC = 3'd5;

  localparam logic signed [DOS_W-1:0] DOS_MAX = 48'sh7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] energy;
  } req_t;

  typedef struct packed {
    logic [9:0]               bin_index;
    logic [1:0]               range_status;
    logic                     first_visit;
    logic signed [DOS_W-1:0]  dos_value;
    logic                     flat;
    logic [10:0]              bins_failing;
    logic [15:0]              not_improved_count;
    logic [15:0]              refresh_count;
    logic [31:0]              below_count;
    logic [31:0]              above_count;
  } rsp_t;

endpackage

// ===== rtl/wang_landau_histogram_dos_unit.sv =====
// Top level: Wang-Landau histogram, log-DOS and visited map with sequencer.
//
//  channel   | signals                          | handshake
//  ----------+----------------------------------+-------------------------------
//  request   | start, busy, request (req_t)     | taken when start && !busy
//  result    | done, result (rsp_t)             | one-cycle strobe, no stall
//  config    | cfg_we, cfg_index, cfg_data      | written on cfg_we; user writes idle only, unchecked
//
//  An out-of-range update skips the divider. An update of an in-range bin waits
//  for the 32-step divider; a first visit adds a hit clear sweep. A flatness
//  check makes two sweeps over the RAMs; a clear makes one hit clear sweep.
//  After reset a clearing pass over all MAX_BINS entries runs with busy high.
//  Results cannot be stalled; each is shown for exactly one cycle.
`timescale 1ns / 1ps
module wang_landau_histogram_dos_unit import wldos_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 request,
  output logic                 done,
  output rsp_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam int IW     = $clog2(MAX_BINS);
  localparam int NW     = $clog2(MAX_BINS + 1);
  localparam int SUM_W  = HIT_W + NW;
  localparam int RHS_W  = FRAC_W + SUM_W;
  localparam int LHS_W  = SUM_W + 16;
  localparam int LO_W   = (SUM_W + 1) / 2;
  localparam int N_RST  = (int'(BINS_RST) > MAX_BINS) ? MAX_BINS : int'(BINS_RST);

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_RD    = 13'b0000000001000,
    S_SELF  = 13'b0000000010000,
    S_NB_LO = 13'b0000000100000,
    S_NB_HI = 13'b0000001000000,
    S_PICK  = 13'b0000010000000,
    S_CLR   = 13'b0000100000000,
    S_SUM   = 13'b0001000000000,
    S_MUL   = 13'b0010000000000,
    S_FAIL  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state;

  logic signed [31:0] energy_min, energy_max;
  logic [30:0]        bin_width;
  logic [10:0]        bins_in_use;
  logic [31:0]        mod_factor;
  logic [16:0]        flatness_fraction;

  logic [NW-1:0]   failing;
  logic [15:0]     not_improved, refreshes;
  logic [31:0]     below_range, above_range;

  logic [1:0]              kind;
  logic [IW-1:0]           idx, cnt;
  logic [1:0]              status;
  logic                    first;
  logic signed [DOS_W-1:0] dos_out, lo_dos;
  logic                    lo_vis, flat_q;
  logic                    rd_end, pend;
  logic [SUM_W-1:0]        sum;
  logic [NW-1:0]           vcnt, fails;
  logic [RHS_W-1:0]        rhs;

  logic [NW-1:0]           n;
  logic [IW-1:0]           n_last, nb_a, nb_b, raddr;
  logic [32:0]             diff_full;
  logic [30:0]             wdiv;
  logic                    div_go, div_done;
  logic [DIV_W-1:0]        quot;
  logic                    dos_we, hit_we;
  logic [IW-1:0]           dos_wa, hit_wa;
  logic [DOS_W:0]          dos_wd, dos_rd;
  logic [HIT_W-1:0]        hit_wd, hit_rd;
  logic signed [DOS_W:0]   dos_sum;
  logic signed [DOS_W-1:0] dos_inc, rd_dos, pick;
  logic                    rd_vis;
  logic [HIT_W-1:0]        hit_inc;
  logic [SUM_W-1:0]        prod;
  logic [LHS_W-1:0]        lhs;
  logic [LO_W-1:0]         mul_b;
  logic [FRAC_W+LO_W-1:0]  mul_p;
  logic                    accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (32'(bins_in_use) < 32'd2) begin
      n = NW'(2);
    end else if (32'(bins_in_use) > 32'(MAX_BINS)) begin
      n = NW'(MAX_BINS);
    end else begin
      n = NW'(bins_in_use);
    end
  end

  assign n_last    = IW'(n - NW'(1));
  assign nb_a      = (idx == '0) ? IW'(1) : idx - IW'(1);
  assign nb_b      = (idx == n_last) ? idx - IW'(1) : idx + IW'(1);
  assign diff_full = {request.energy[31], request.energy} - {energy_min[31], energy_min};
  assign wdiv      = (bin_width == '0) ? 31'd1 : bin_width;
  assign div_go    = accept && request.kind == KIND_UPDATE
                     && request.energy >= energy_min && request.energy <= energy_max;

  assign rd_dos  = $signed(dos_rd[DOS_W-1:0]);
  assign rd_vis  = dos_rd[DOS_W];
  assign dos_sum = {rd_dos[DOS_W-1], rd_dos} + $signed({17'd0, mod_factor});
  assign dos_inc = (dos_sum[DOS_W] != dos_sum[DOS_W-1]) ? DOS_MAX : dos_sum[DOS_W-1:0];
  assign hit_inc = (hit_rd == '1) ? hit_rd : hit_rd + HIT_W'(1);
  assign prod    = hit_rd * vcnt;
  assign lhs     = {prod, 16'd0};
  assign mul_b   = pend ? LO_W'(sum[SUM_W-1:LO_W]) : sum[LO_W-1:0];
  assign mul_p   = flatness_fraction * mul_b;

  always_comb begin
    if (lo_vis && rd_vis) begin
      pick = (lo_dos < rd_dos) ? lo_dos : rd_dos;
    end else if (!lo_vis) begin
      pick = rd_dos;
    end else begin
      pick = lo_dos;
    end
  end

  always_comb begin
    unique case (state)
      S_RD:    raddr = idx;
      S_NB_LO: raddr = nb_a;
      S_NB_HI: raddr = nb_b;
      default: raddr = cnt;
    endcase
  end

  always_comb begin
    dos_we = 1'b0;
    dos_wa = idx;
    dos_wd = {1'b1, dos_inc};
    hit_we = 1'b0;
    hit_wa = idx;
    hit_wd = hit_inc;
    unique case (state)
      S_INIT: begin
        dos_we = 1'b1;
        dos_wa = cnt;
        dos_wd = '0;
        hit_we = 1'b1;
        hit_wa = cnt;
        hit_wd = '0;
      end
      S_SELF: begin
        dos_we = rd_vis;
        hit_we = rd_vis;
      end
      S_PICK: begin
        dos_we = 1'b1;
        dos_wd = {1'b1, pick};
      end
      S_CLR: begin
        hit_we = 1'b1;
        hit_wa = cnt;
        hit_wd = '0;
      end
      default: begin
      end
    endcase
  end

  wldos_ram #(.WIDTH(DOS_W + 1), .DEPTH(MAX_BINS)) u_dos_ram (
    .clk(clk), .we(dos_we), .waddr(dos_wa), .wdata(dos_wd), .raddr(raddr), .rdata(dos_rd)
  );

  wldos_ram #(.WIDTH(HIT_W), .DEPTH(MAX_BINS)) u_hit_ram (
    .clk(clk), .we(hit_we), .waddr(hit_wa), .wdata(hit_wd), .raddr(raddr), .rdata(hit_rd)
  );

  wldos_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(diff_full[31:0]), .divisor(wdiv),
    .done(div_done), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_min        <= EMIN_RST;
      energy_max        <= EMAX_RST;
      bin_width         <= BINW_RST;
      bins_in_use       <= BINS_RST;
      mod_factor        <= MODF_RST;
      flatness_fraction <= FRAC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EMIN: energy_min        <= $signed(cfg_data);
        REG_EMAX: energy_max        <= $signed(cfg_data);
        REG_BINW: bin_width         <= cfg_data[30:0];
        REG_BINS: bins_in_use       <= cfg_data[10:0];
        REG_MODF: mod_factor        <= cfg_data;
        REG_FRAC: flatness_fraction <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cnt          <= '0;
      done         <= 1'b0;
      failing      <= NW'(N_RST);
      not_improved <= '0;
      refreshes    <= '0;
      below_range  <= '0;
      above_range  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          cnt <= cnt + IW'(1);
          if (cnt == IW'(MAX_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind    <= request.kind;
            status  <= RS_IN;
            first   <= 1'b0;
            dos_out <= '0;
            idx     <= '0;
            flat_q  <= 1'b0;
            cnt     <= '0;
            rd_end  <= 1'b0;
            pend    <= 1'b0;
            sum     <= '0;
            vcnt    <= '0;
            fails   <= '0;
            unique case (request.kind)
              KIND_UPDATE: begin
                if (request.energy < energy_min) begin
                  status <= RS_BELOW;
                  if (below_range != '1) begin
                    below_range <= below_range + 32'd1;
                  end
                  state <= S_FIN;
                end else if (request.energy > energy_max) begin
                  status <= RS_ABOVE;
                  if (above_range != '1) begin
                    above_range <= above_range + 32'd1;
                  end
                  state <= S_FIN;
                end else begin
                  state <= S_DIV;
                end
              end
              KIND_CHECK: state <= S_SUM;
              KIND_CLEAR: state <= S_CLR;
              default:    state <= S_FIN;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            idx   <= (quot >= DIV_W'(n)) ? n_last : IW'(quot);
            state <= S_RD;
          end
        end
        S_RD: state <= S_SELF;
        S_SELF: begin
          if (rd_vis) begin
            dos_out <= dos_inc;
            state   <= S_FIN;
          end else begin
            state <= S_NB_LO;
          end
        end
        S_NB_LO: state <= S_NB_HI;
        S_NB_HI: begin
          lo_dos <= rd_dos;
          lo_vis <= rd_vis;
          state  <= S_PICK;
        end
        S_PICK: begin
          dos_out <= pick;
          first   <= 1'b1;
          cnt     <= '0;
          state   <= S_CLR;
        end
        S_CLR: begin
          cnt <= cnt + IW'(1);
          if (cnt == n_last) begin
            not_improved <= '0;
            failing      <= n;
            if (kind == KIND_CLEAR) begin
              refreshes <= '0;
            end else if (refreshes != '1) begin
              refreshes <= refreshes + 16'd1;
            end
            state <= S_FIN;
          end
        end
        S_SUM: begin
          pend <= !rd_end;
          if (!rd_end) begin
            cnt <= cnt + IW'(1);
            if (cnt == n_last) begin
              rd_end <= 1'b1;
            end
          end
          if (pend && rd_vis) begin
            sum  <= sum + SUM_W'(hit_rd);
            vcnt <= vcnt + NW'(1);
          end
          if (rd_end && !pend) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (!pend) begin
            rhs  <= RHS_W'(mul_p);
            pend <= 1'b1;
          end else begin
            rhs    <= rhs + (RHS_W'(mul_p) << LO_W);
            cnt    <= '0;
            rd_end <= 1'b0;
            pend   <= 1'b0;
            state  <= S_FAIL;
          end
        end
        S_FAIL: begin
          pend <= !rd_end;
          if (!rd_end) begin
            cnt <= cnt + IW'(1);
            if (cnt == n_last) begin
              rd_end <= 1'b1;
            end
          end
          if (pend && rd_vis && RHS_W'(lhs) < rhs) begin
            fails <= fails + NW'(1);
          end
          if (rd_end && !pend) begin
            failing <= fails;
            if (fails >= failing && not_improved != '1) begin
              not_improved <= not_improved + 16'd1;
            end
            flat_q <= (fails == '0);
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          done                      <= 1'b1;
          result.bin_index          <= 10'(idx);
          result.range_status       <= status;
          result.first_visit        <= first;
          result.dos_value          <= dos_out;
          result.flat               <= flat_q;
          result.bins_failing       <= 11'(failing);
          result.not_improved_count <= not_improved;
          result.refresh_count      <= refreshes;
          result.below_count        <= below_range;
          result.above_count        <= above_range;
          state                     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without work");
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("request taken but unit idle");
  assert property (@(posedge clk) disable iff (rst)
    done && result.first_visit |-> result.range_status == RS_IN)
    else $error("first visit outside range");
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("divider finished outside divide wait");
endmodule

// ===== rtl/wldos_ram.sv =====
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module wldos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/wldos_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wldos_div import wldos_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);
  localparam int CW = $clog2(DIV_W + 1);

  logic [DIVR_W-1:0] dsr;
  logic [DIVR_W-1:0] rem;
  logic [CW-1:0]     cnt;
  logic              run;
  logic [DIV_W-1:0]  trial;
  logic              take;

  assign trial = {rem, quotient[DIV_W-1]};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run      <= 1'b1;
        cnt      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
      end else if (run) begin
        if (take) begin
          rem <= DIVR_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DIVR_W-1:0];
        end
        quotient <= {quotient[DIV_W-2:0], take};
        cnt      <= cnt + CW'(1);
        if (cnt == CW'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !run);
endmodule
